/* sv/uuld_pkg.sv */
package uuld_pkg;

  // Widths of the capacity register and of the running byte count
  localparam int CAP_W = 16;
  localparam int CNT_W = 16;
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CAP_W-1:0] CAP_RESET = '1;

  // Width of the bytes_so_far field on the result stream
  localparam int OUT_CNT_W = 16;

  // Results one text byte can cause, and result queue sizing
  localparam int RES_MAX = 3;
  localparam int Q_DEPTH = 6;
  localparam int QIDX_W = $clog2(Q_DEPTH);
  localparam int QCNT_W = $clog2(Q_DEPTH + 1);

  // Character constants
  localparam logic [7:0] SPACE_CHR = 8'h20;
  localparam logic [7:0] HIGH_CHR = 8'h80;
  localparam logic [7:0] NUL_CHR = 8'h00;

  // Decoder phase, one-hot
  typedef enum logic [4:0] {
    PH_LINE  = 5'b00001,
    PH_DATA  = 5'b00010,
    PH_TEXT  = 5'b00100,
    PH_SPACE = 5'b01000,
    PH_STOP  = 5'b10000
  } phase_e;

  // One result item
  typedef struct packed {
    logic [7:0]           data;
    logic                 present;
    logic                 run_last;
    logic                 done;
    logic [OUT_CNT_W-1:0] count;
  } res_t;

endpackage

/* sv/uu_line_decoder_top.sv */
// Streaming uudecode: text bytes enter on the slave stream (tlast marks the last
// byte of a message) and decoded bytes leave on the master stream, one result
// item per handshake. A text byte is taken every cycle while the six-entry
// result queue holds three items or fewer; a byte that completes a group of four
// sextets adds up to three items, and the queue drains one item per cycle while
// the receiver is ready; four text bytes give three decoded bytes. Each text
// byte passes an input register, combinational decode logic, and the result
// queue. Write the capacity register only while no results are pending.
module uu_line_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // message_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] decoded_byte, [23:8] bytes_so_far
  output logic [1:0]  m_axis_tuser,   // [0] byte_present, [1] message_done
  output logic        m_axis_tlast    // run_last
);
  import uuld_pkg::*;

  logic               in_vld_q, in_vld_d;
  logic [7:0]         in_byte_q;
  logic               in_last_q;
  logic               fire;
  logic               in_acc;
  res_t [RES_MAX-1:0] res;
  logic [1:0]         num;
  res_t               head;
  logic [QCNT_W-1:0]  q_cnt;

  // Decode the held byte once the queue has room for a full group
  assign fire          = in_vld_q && (q_cnt <= QCNT_W'(Q_DEPTH - RES_MAX));
  assign s_axis_tready = !in_vld_q || fire;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = in_acc ? 1'b1 : (fire ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Load the input item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  uuld_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (fire),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .res_o       (res),
    .num_o       (num)
  );

  uuld_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res),
    .num_i   (num),
    .ready_i (m_axis_tready),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .count_o (q_cnt)
  );

  // Pack the head result onto the master stream
  assign m_axis_tdata = {head.count, head.data};
  assign m_axis_tuser = {head.done, head.present};
  assign m_axis_tlast = head.run_last;

endmodule

/* sv/uuld_decode.sv */
module uuld_decode (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [uuld_pkg::CAP_W-1:0]            cfg_wdata_i,
  input  logic                                  step_i,
  input  logic [7:0]                            byte_i,
  input  logic                                  last_i,
  output uuld_pkg::res_t [uuld_pkg::RES_MAX-1:0] res_o,
  output logic [1:0]                            num_o
);
  import uuld_pkg::*;

  logic [CAP_W-1:0] cap_q;
  phase_e           phase_q, phase_d;
  logic [5:0]       line_len_q, line_len_d;
  logic [6:0]       line_dec_q, line_dec_d;
  logic [1:0]       sext_idx_q, sext_idx_d;
  logic [2:0][5:0]  held_q, held_d;
  logic [CNT_W-1:0] emit_q, emit_d;

  logic [LIM_W-1:0] lim;
  logic [LIM_W-1:0] emit_ext;
  logic [LIM_W-1:0] rem;
  logic [1:0]       take;
  logic [5:0]       sext;
  logic [3:0][5:0]  quad;
  logic [2:0][7:0]  dec;

  res_t [RES_MAX-1:0] res_v;
  logic [1:0]         num_v;
  logic               stop;
  logic               consumed;
  phase_e             ph;

  // Effective limit: capacity, clamped to the count range
  always_comb begin
    if (LIM_W'(cap_q) < LIM_W'(CNT_MAX)) begin
      lim = LIM_W'(cap_q);
    end else begin
      lim = LIM_W'(CNT_MAX);
    end
  end

  assign emit_ext = LIM_W'(emit_q);
  assign rem      = lim - emit_ext;
  assign take     = (rem >= LIM_W'(RES_MAX)) ? 2'(RES_MAX) : rem[1:0];

  // Strip the space bias from a data byte
  assign sext = (byte_i >= SPACE_CHR) ? 6'(byte_i - SPACE_CHR) : byte_i[5:0];

  // Assemble the group of four and split it into three bytes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < sext_idx_q) begin
        quad[i] = held_q[i];
      end else if (2'(i) == sext_idx_q) begin
        quad[i] = sext;
      end else begin
        quad[i] = '0;
      end
    end
    quad[3] = (sext_idx_q == 2'd3) ? sext : 6'd0;
    dec[0] = {quad[0], quad[1][5:4]};
    dec[1] = {quad[1][3:0], quad[2][5:2]};
    dec[2] = {quad[2][1:0], quad[3]};
  end

  // Advance the decoder by one text byte
  always_comb begin
    phase_d    = phase_q;
    line_len_d = line_len_q;
    line_dec_d = line_dec_q;
    sext_idx_d = sext_idx_q;
    held_d     = held_q;
    emit_d     = emit_q;
    res_v      = '0;
    num_v      = 2'd0;
    stop       = 1'b0;
    consumed   = 1'b0;
    ph         = phase_q;

    if (step_i) begin
      if (phase_q == PH_STOP) begin
        if (last_i) begin
          phase_d    = PH_LINE;
          line_len_d = '0;
          line_dec_d = '0;
          sext_idx_d = '0;
          held_d     = '0;
          emit_d     = '0;
        end
      end else begin
        if (emit_ext >= lim) begin
          stop = 1'b1;
        end else if (phase_q == PH_DATA) begin
          if (sext_idx_q != 2'd3 && !last_i) begin
            held_d[sext_idx_q] = sext;
            sext_idx_d         = sext_idx_q + 2'd1;
          end else begin
            for (int j = 0; j < RES_MAX; j++) begin
              if (2'(j) < take) begin
                res_v[j].data    = dec[j];
                res_v[j].present = 1'b1;
                res_v[j].count   = OUT_CNT_W'(emit_q + CNT_W'(j + 1));
              end
            end
            num_v  = take;
            emit_d = emit_q + CNT_W'(take);
            if (emit_ext + LIM_W'(take) >= lim) begin
              stop = 1'b1;
            end
            sext_idx_d = '0;
            held_d     = '0;
            line_dec_d = line_dec_q + 7'd3;
            if (line_dec_d >= 7'(line_len_q)) begin
              phase_d = PH_TEXT;
            end
          end
        end else begin
          // Skip the line tail, then whitespace, then read the length byte
          if (ph == PH_TEXT) begin
            if (byte_i > SPACE_CHR && byte_i < HIGH_CHR) begin
              consumed = 1'b1;
            end else begin
              ph = PH_SPACE;
            end
          end
          if (ph == PH_SPACE && !consumed) begin
            if (byte_i != NUL_CHR && (byte_i <= SPACE_CHR || byte_i >= HIGH_CHR)) begin
              consumed = 1'b1;
            end else begin
              ph = PH_LINE;
            end
          end
          if (ph == PH_LINE && !consumed) begin
            if (byte_i >= SPACE_CHR && byte_i < HIGH_CHR) begin
              if (sext == 6'd0 || last_i) begin
                stop = 1'b1;
              end else begin
                line_len_d = sext;
                line_dec_d = '0;
                sext_idx_d = '0;
                ph         = PH_DATA;
              end
            end
          end
          phase_d = ph;
        end

        // Close the message or stop decoding
        if (stop || last_i) begin
          if (num_v == 2'd0) begin
            res_v[0].count = OUT_CNT_W'(emit_q);
            num_v          = 2'd1;
          end
          for (int j = 0; j < RES_MAX; j++) begin
            if (2'(j + 1) == num_v) begin
              res_v[j].done = 1'b1;
            end
          end
          if (last_i) begin
            phase_d    = PH_LINE;
            line_len_d = '0;
            line_dec_d = '0;
            sext_idx_d = '0;
            held_d     = '0;
            emit_d     = '0;
          end else begin
            phase_d = PH_STOP;
          end
        end
        for (int j = 0; j < RES_MAX; j++) begin
          if (2'(j + 1) == num_v) begin
            res_v[j].run_last = 1'b1;
          end
        end
      end
    end
  end

  assign res_o = res_v;
  assign num_o = num_v;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LINE;
      line_len_q <= '0;
      line_dec_q <= '0;
      sext_idx_q <= '0;
      held_q     <= '0;
      emit_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      line_len_q <= line_len_d;
      line_dec_q <= line_dec_d;
      sext_idx_q <= sext_idx_d;
      held_q     <= held_d;
      emit_q     <= emit_d;
    end
  end

  // A line never decodes more than one group past its length
  a_line_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_dec_q <= 7'(line_len_q) + 7'd2)
    else $error("line decode count ran past its length");

endmodule

/* sv/uuld_queue.sv */
module uuld_queue (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  uuld_pkg::res_t [uuld_pkg::RES_MAX-1:0] push_i,
  input  logic [1:0]                             num_i,
  input  logic                                   ready_i,
  output uuld_pkg::res_t                         head_o,
  output logic                                   valid_o,
  output logic [uuld_pkg::QCNT_W-1:0]            count_o
);
  import uuld_pkg::*;

  res_t [Q_DEPTH-1:0] ent_q, ent_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic [QCNT_W-1:0]  base;
  logic [QCNT_W-1:0]  slot;
  logic               pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign base    = cnt_q - QCNT_W'(pop);

  // Shift out the head on pop, then append the new results
  always_comb begin
    ent_d = ent_q;
    slot  = '0;
    if (pop) begin
      for (int i = 0; i < Q_DEPTH - 1; i++) begin
        ent_d[i] = ent_q[i + 1];
      end
    end
    for (int j = 0; j < RES_MAX; j++) begin
      slot = base + QCNT_W'(j);
      if (2'(j) < num_i) begin
        ent_d[slot[QIDX_W-1:0]] = push_i[j];
      end
    end
  end

  assign cnt_d   = base + QCNT_W'(num_i);
  assign head_o  = ent_q[0];
  assign count_o = cnt_q;

  // Hold the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold the entries
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(Q_DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (num_i != 2'd0) |-> ((QCNT_W + 1)'(base) + (QCNT_W + 1)'(num_i) <= (QCNT_W + 1)'(Q_DEPTH)))
    else $error("result queue overflow");

  a_run_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !head_o.run_last) |-> (cnt_q >= QCNT_W'(2)))
    else $error("results of one text byte split in the queue");

endmodule

/* tb/tb_uu_line_decoder_top.sv */
module tb_uu_line_decoder_top;
  import uuld_pkg::*;

  localparam int          CLK_HALF        = 5;
  localparam int          TIMEOUT         = 2000000;
  localparam int          DRAIN_CYCLES    = 8;
  localparam int          HOLD_OFF_CYCLES = 120;
  localparam int unsigned RANDOM_ITEMS    = 250;

  // Characters that shape the text
  localparam logic [7:0] GRAVE_CHR = 8'h60;
  localparam logic [7:0] NL_CHR    = 8'h0a;
  localparam logic [7:0] CR_CHR    = 8'h0d;
  localparam logic [7:0] TAB_CHR   = 8'h09;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_PATTERN,
    SINK_RANDOM
  } sink_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] text_byte
  logic        s_axis_tlast  = 1'b0; // message_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [7:0] decoded_byte, [23:8] bytes_so_far
  logic [1:0]  m_axis_tuser;         // [0] byte_present, [1] message_done
  logic        m_axis_tlast;         // run_last

  uu_line_decoder_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Decoder state mirrored from the accepted text
  phase_e           msg_phase   = PH_LINE;
  logic [5:0]       line_len    = '0;
  logic [6:0]       line_done   = '0;
  logic [1:0]       sextet_idx  = '0;
  logic [7:0]       held [3]    = '{default: '0};
  logic [CNT_W-1:0] emitted     = '0;
  logic [CAP_W-1:0] capacity    = CAP_RESET;

  res_t             pending_results [$];
  logic [7:0]       text_buf [$];
  int unsigned      live_items     = 0;
  int unsigned      mismatch_count = 0;

  // Sender and receiver idling controls
  bit               src_bursty    = 1'b1;
  int unsigned      burst_left    = 0;
  sink_mode_e       sink_mode     = SINK_OPEN;
  logic [15:0]      sink_pattern  = 16'hffff;
  bit               hold_off_req  = 1'b0;

  function automatic void start_message();
    msg_phase  = PH_LINE;
    line_len   = '0;
    line_done  = '0;
    sextet_idx = '0;
    held       = '{default: '0};
    emitted    = '0;
  endfunction

  // Work out the result items that one accepted text byte causes
  function automatic void decode_text_byte(logic [7:0] b, logic last);
    res_t             outs [RES_MAX];
    int               n;
    logic             stop;
    logic             taken;
    logic [7:0]       c;
    logic [7:0]       diff;
    logic [7:0]       grp [4];
    logic [7:0]       d [3];
    logic [LIM_W-1:0] limit;
    n     = 0;
    stop  = 1'b0;
    taken = 1'b0;
    limit = (capacity < CNT_MAX) ? LIM_W'(capacity) : LIM_W'(CNT_MAX);
    live_items++;

    // Drop everything after decoding stopped, up to the message end
    if (msg_phase == PH_STOP) begin
      if (last) start_message();
      return;
    end

    if (LIM_W'(emitted) >= limit) begin
      stop = 1'b1;
    end else if (msg_phase == PH_DATA) begin
      c = (b >= SPACE_CHR) ? b - SPACE_CHR : b;
      if (sextet_idx < 2'd3 && !last) begin
        held[sextet_idx] = c;
        sextet_idx++;
      end else begin
        grp = '{default: '0};
        for (int i = 0; i < 3; i++)
          if (i < int'(sextet_idx)) grp[i] = held[i];
        grp[sextet_idx] = c;
        d[0] = {grp[0][5:0], grp[1][5:4]};
        d[1] = {grp[1][3:0], grp[2][5:2]};
        d[2] = {grp[2][1:0], grp[3][5:0]};
        for (int i = 0; i < 3; i++) begin
          if (LIM_W'(emitted) < limit) begin
            emitted++;
            outs[n]         = '0;
            outs[n].data    = d[i];
            outs[n].present = 1'b1;
            outs[n].count   = OUT_CNT_W'(emitted);
            n++;
          end
        end
        if (LIM_W'(emitted) >= limit) stop = 1'b1;
        sextet_idx = '0;
        held       = '{default: '0};
        line_done  = line_done + 7'd3;
        if (line_done >= {1'b0, line_len}) msg_phase = PH_TEXT;
      end
    end else begin
      // Skip the rest of the line text, then whitespace, then find a length
      if (msg_phase == PH_TEXT) begin
        if (b > SPACE_CHR && b < HIGH_CHR) taken = 1'b1;
        else msg_phase = PH_SPACE;
      end
      if (msg_phase == PH_SPACE && !taken) begin
        if (b != NUL_CHR && (b <= SPACE_CHR || b >= HIGH_CHR)) taken = 1'b1;
        else msg_phase = PH_LINE;
      end
      if (msg_phase == PH_LINE && !taken) begin
        if (b >= SPACE_CHR && b < HIGH_CHR) begin
          diff = b - SPACE_CHR;
          if (diff[5:0] == 6'd0 || last) begin
            stop = 1'b1;
          end else begin
            line_len   = diff[5:0];
            line_done  = '0;
            sextet_idx = '0;
            msg_phase  = PH_DATA;
          end
        end
      end
    end

    // Close the message with a done flag, adding a bare marker if needed
    if (stop || last) begin
      if (n == 0) begin
        outs[0]       = '0;
        outs[0].count = OUT_CNT_W'(emitted);
        n = 1;
      end
      outs[n-1].done = 1'b1;
      if (last) start_message();
      else msg_phase = PH_STOP;
    end
    if (n > 0) outs[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(outs[i]);
  endfunction

  // Predict on every accepted text byte
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      decode_text_byte(s_axis_tdata, s_axis_tlast);
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each decoded item with the oldest expectation
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("decoded item with no expectation: data %0h", m_axis_tdata[7:0]);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("decoded_byte", 32'(want.data), 32'(m_axis_tdata[7:0]));
        check_field("byte_present", 32'(want.present), 32'(m_axis_tuser[0]));
        check_field("run_last", 32'(want.run_last), 32'(m_axis_tlast));
        check_field("message_done", 32'(want.done), 32'(m_axis_tuser[1]));
        check_field("bytes_so_far", 32'(want.count), 32'(m_axis_tdata[23:8]));
      end
    end
  end

  // Receiver: stall per mode, or hold off for a long stretch on request
  initial begin : sink
    int          held_cycles;
    logic [3:0]  pat_pos;
    int unsigned r;
    pat_pos = '0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (held_cycles = 0; held_cycles < HOLD_OFF_CYCLES; held_cycles++)
          @(posedge clk_i);
      end else begin
        case (sink_mode)
          SINK_OPEN:    m_axis_tready <= 1'b1;
          SINK_PATTERN: begin
            m_axis_tready <= sink_pattern[pat_pos];
            pat_pos++;
          end
          default: begin
            r = $urandom_range(0, 3);
            m_axis_tready <= (r != 0);
          end
        endcase
      end
    end
  end

  function automatic logic [7:0] rand_char(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(lo, hi);
    return r[7:0];
  endfunction

  // Encode a sextet, sometimes with bit 6 or bit 7 set, which decode alike
  function automatic logic [7:0] sextet_char(logic [5:0] s);
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return {2'b10, s} + SPACE_CHR;
    if (pick == 1 && !s[5]) return {2'b01, s} + SPACE_CHR;
    return {2'b00, s} + SPACE_CHR;
  endfunction

  function automatic logic [7:0] len_char(logic [5:0] n);
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0 && !n[5]) return {2'b01, n} + SPACE_CHR;
    return {2'b00, n} + SPACE_CHR;
  endfunction

  function automatic void add_line(logic [5:0] n);
    logic [7:0] x0, x1, x2;
    text_buf.push_back(len_char(n));
    for (int g = 0; g < (int'(n) + 2) / 3; g++) begin
      x0 = rand_char(0, 255);
      x1 = rand_char(0, 255);
      x2 = rand_char(0, 255);
      text_buf.push_back(sextet_char(x0[7:2]));
      text_buf.push_back(sextet_char({x0[1:0], x1[7:4]}));
      text_buf.push_back(sextet_char({x1[3:0], x2[7:6]}));
      text_buf.push_back(sextet_char(x2[5:0]));
    end
  endfunction

  // Trailing line text, then a line break of some flavor
  function automatic void add_line_break();
    int unsigned extra;
    extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    for (int k = 0; k < int'(extra); k++) text_buf.push_back(rand_char(8'h21, 8'h7f));
    case ($urandom_range(0, 7))
      0: begin text_buf.push_back(CR_CHR); text_buf.push_back(NL_CHR); end
      1: begin text_buf.push_back(SPACE_CHR); text_buf.push_back(NL_CHR); end
      2: begin text_buf.push_back(TAB_CHR); text_buf.push_back(NL_CHR); end
      3: begin text_buf.push_back(rand_char(8'h80, 8'hff)); text_buf.push_back(NL_CHR); end
      4: begin text_buf.push_back(NUL_CHR); text_buf.push_back(CR_CHR); end
      default: text_buf.push_back(NL_CHR);
    endcase
  endfunction

  function automatic void add_message(int unsigned lines);
    int unsigned r;
    if ($urandom_range(0, 4) == 0) text_buf.push_back(rand_char(0, 31));
    if ($urandom_range(0, 4) == 0) text_buf.push_back(rand_char(8'h80, 8'hff));
    for (int l = 0; l < int'(lines); l++) begin
      r = ($urandom_range(0, 7) == 0) ? $urandom_range(46, 63) : $urandom_range(1, 45);
      add_line(r[5:0]);
      add_line_break();
    end
    text_buf.push_back($urandom_range(0, 1) ? GRAVE_CHR : SPACE_CHR);
    if ($urandom_range(0, 1)) text_buf.push_back(NL_CHR);
  endfunction

  // Offer one text byte and hold it until it is taken
  task automatic send_text(input logic [7:0] text, input logic ends);
    int unsigned gap;
    if (src_bursty && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left != 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= text;
    s_axis_tlast  <= ends;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_buf();
    for (int i = 0; i < text_buf.size(); i++)
      send_text(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  // Drain all expected items, then let the pipeline settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [15:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    capacity = value;
  endtask

  // Control and high bytes skipped at line start, extreme data characters
  task automatic test_line_start_and_extremes();
    sink_mode  = SINK_RANDOM;
    src_bursty = 1'b1;
    set_capacity(CAP_RESET);
    send_text(8'h00, 1'b0);
    send_text(8'h1f, 1'b0);
    send_text(8'h80, 1'b0);
    send_text(8'hff, 1'b0);
    send_text(len_char(6'd1), 1'b0);
    send_text(8'h7f, 1'b0);
    send_text(8'hff, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'h20, 1'b0);
    send_text(NL_CHR, 1'b0);
    send_text(GRAVE_CHR, 1'b1);
  endtask

  // Message ends inside a group, and on a length byte
  task automatic test_message_ends();
    send_text(len_char(6'd63), 1'b0);
    send_text(8'h41, 1'b0);
    send_text(8'h3e, 1'b1);
    send_text(8'h4d, 1'b1);
  endtask

  // NUL ends the whitespace skip; a space at line start then stops decoding
  task automatic test_nul_in_gap();
    send_text(len_char(6'd2), 1'b0);
    for (int i = 0; i < 4; i++) send_text(sextet_char(6'h2a), 1'b0);
    send_text(8'h78, 1'b0);
    send_text(NUL_CHR, 1'b0);
    send_text(TAB_CHR, 1'b0);
    send_text(SPACE_CHR, 1'b0);
    send_text(8'h51, 1'b0);
    send_text(8'h51, 1'b1);
  endtask

  // Zero capacity, a small capacity, and a capacity lowered mid-message
  task automatic test_capacity();
    wait_idle();
    set_capacity(16'd0);
    send_text(len_char(6'd3), 1'b0);
    send_text(NL_CHR, 1'b1);
    wait_idle();
    set_capacity(16'd4);
    add_line(6'd6);
    text_buf.push_back(NL_CHR);
    send_buf();
    wait_idle();
    set_capacity(CAP_RESET);
    send_text(len_char(6'd3), 1'b0);
    for (int i = 0; i < 4; i++) send_text(sextet_char(6'h15), 1'b0);
    wait_idle();
    set_capacity(16'd2);
    send_text(NL_CHR, 1'b1);
    wait_idle();
    set_capacity(CAP_RESET);
  endtask

  // Stall the receiver long enough that the block must stall its input
  task automatic test_backpressure();
    wait_idle();
    sink_mode  = SINK_OPEN;
    src_bursty = 1'b0;
    hold_off_req = 1'b1;
    for (int l = 0; l < 3; l++) begin
      add_line(6'd45);
      text_buf.push_back(NL_CHR);
    end
    text_buf.push_back(GRAVE_CHR);
    send_buf();
  endtask

  // Mostly well-formed messages with random content; some cut short or noise
  task automatic test_random_messages();
    int unsigned start;
    int unsigned kind;
    int unsigned r;
    int unsigned cut;
    start = live_items;
    while (live_items - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        wait_idle();
        case ($urandom_range(0, 5))
          0:       r = $urandom_range(0, 3);
          1, 2:    r = $urandom_range(4, 60);
          3:       r = $urandom_range(0, 65535);
          default: r = 32'(CAP_RESET);
        endcase
        set_capacity(r[15:0]);
      end
      sink_mode    = sink_mode_e'($urandom_range(0, 2));
      r            = $urandom;
      sink_pattern = r[15:0] | 16'h0001;
      src_bursty   = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        add_message($urandom_range(1, 3));
      end else if (kind == 7) begin
        add_message($urandom_range(1, 2));
        cut = $urandom_range(1, text_buf.size());
        text_buf = text_buf[0:cut-1];
      end else begin
        r = $urandom_range(1, 12);
        for (int i = 0; i < int'(r); i++) text_buf.push_back(rand_char(0, 255));
      end
      send_buf();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_line_start_and_extremes();
    test_message_ends();
    test_nul_in_gap();
    test_capacity();
    test_backpressure();
    test_random_messages();
    wait_idle();
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #TIMEOUT;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
sv/uuld_pkg.sv
sv/uuld_decode.sv
sv/uuld_queue.sv
sv/uu_line_decoder_top.sv
tb/tb_uu_line_decoder_top.sv
